// ===== src/csl_pkg.sv =====
// Shared constants, token kinds and character classes for the C subset lexer.
package csl_pkg;

    localparam int POS_BITS_DEF   = 16;
    localparam int VALUE_BITS_DEF = 31;

    localparam int MAX_RESULTS = 3;
    localparam int Q_DEPTH     = 4;

    typedef enum logic [2:0] {
        KIND_PUNCT   = 3'd0,
        KIND_NUM     = 3'd1,
        KIND_IDENT   = 3'd2,
        KIND_KEYWORD = 3'd3,
        KIND_END     = 3'd4,
        KIND_BAD     = 3'd5
    } t_token_kind;

    localparam logic [7:0] CH_EQ   = 8'h3d;
    localparam logic [7:0] CH_LT   = 8'h3c;
    localparam logic [7:0] CH_GT   = 8'h3e;
    localparam logic [7:0] CH_BANG = 8'h21;

    // Keywords packed big-end first, right aligned in the six-byte prefix
    localparam logic [47:0] KW_RETURN = 48'h72_65_74_75_72_6e;
    localparam logic [47:0] KW_IF     = 48'h00_00_00_00_69_66;
    localparam logic [47:0] KW_ELSE   = 48'h00_00_65_6c_73_65;
    localparam logic [47:0] KW_WHILE  = 48'h00_77_68_69_6c_65;
    localparam logic [47:0] KW_FOR    = 48'h00_00_00_66_6f_72;

    localparam int KW_RETURN_LEN = 6;
    localparam int KW_IF_LEN     = 2;
    localparam int KW_ELSE_LEN   = 4;
    localparam int KW_WHILE_LEN  = 5;
    localparam int KW_FOR_LEN    = 3;
    localparam int PREFIX_BYTES  = 6;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_ident_head(input logic [7:0] c);
        is_ident_head = ((c >= 8'h61) && (c <= 8'h7a)) ||
                        ((c >= 8'h41) && (c <= 8'h5a)) || (c == 8'h5f);
    endfunction

    function automatic logic is_single(input logic [7:0] c);
        case (c) inside
            8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h28, 8'h29, 8'h3b,
            8'h7b, 8'h7d, 8'h2c, 8'h3c, 8'h3e, 8'h3d: is_single = 1'b1;
            default: is_single = 1'b0;
        endcase
    endfunction

endpackage

// ===== src/csl_token_fifo.sv =====
// Small result queue: takes up to three tokens per cycle, hands out one per cycle while the reader is ready.
module csl_token_fifo #(
    parameter int DATA_W = 80
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,
    input  logic [DATA_W-1:0] i_push_data [csl_pkg::MAX_RESULTS],
    output logic              o_room,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_out_data
);
    localparam int DEPTH = csl_pkg::Q_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_head, r_tail, n_head, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              pop;

    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_mem[r_head];
    assign o_room      = (r_count <= CNT_W'(DEPTH - csl_pkg::MAX_RESULTS));
    assign pop         = o_out_valid && i_out_ready;

    always_comb begin
        n_head  = pop ? r_head + PTR_W'(1) : r_head;
        n_tail  = r_tail + PTR_W'(i_push_cnt);
        n_count = r_count + CNT_W'(i_push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < csl_pkg::MAX_RESULTS; i++) begin
            if (i < int'(i_push_cnt)) begin
                r_mem[r_tail + PTR_W'(i)] <= i_push_data[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

endmodule

// ===== src/csl_scan_core.sv =====
// Input register and scanner state: classifies one byte per cycle into tokens while the result queue has room.
module csl_scan_core #(
    parameter int POS_BITS   = csl_pkg::POS_BITS_DEF,
    parameter int VALUE_BITS = csl_pkg::VALUE_BITS_DEF,
    parameter int TOK_W      = 3 + 2 * POS_BITS + VALUE_BITS + 8 + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_text_byte,
    input  logic             i_end_of_text,
    input  logic             i_room,
    output logic [1:0]       o_push_cnt,
    output logic [TOK_W-1:0] o_push_data [csl_pkg::MAX_RESULTS]
);
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_PUNCT = 3'd1,
        MODE_NUM   = 3'd2,
        MODE_IDENT = 3'd3,
        MODE_ERROR = 3'd4
    } t_scan_mode;

    typedef struct packed {
        csl_pkg::t_token_kind  kind;
        logic [POS_BITS-1:0]   start;
        logic [POS_BITS-1:0]   length;
        logic [VALUE_BITS-1:0] value;
        logic [7:0]            punct;
        logic                  last;
    } t_tok;

    // input word register
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_last;

    // scanner state
    t_scan_mode            r_mode, n_mode;
    logic [POS_BITS-1:0]   r_start, n_start;
    logic [POS_BITS-1:0]   r_len, n_len;
    logic [VALUE_BITS-1:0] r_accum, n_accum;
    logic [47:0]           r_prefix, n_prefix;
    logic [7:0]            r_punct, n_punct;
    logic [POS_BITS-1:0]   r_offset, n_offset;

    logic                  fire;
    logic                  used;
    logic                  va, vm, ve;
    t_tok                  tok_a, tok_m, tok_e;
    t_tok                  slot [csl_pkg::MAX_RESULTS];
    logic [1:0]            cnt;
    logic [3:0]            digit;
    logic [VALUE_BITS+3:0] acc_x10;

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        sat_inc = (v == '1) ? v : v + POS_BITS'(1);
    endfunction

    function automatic logic is_kw(input logic [47:0] p, input logic [POS_BITS-1:0] len);
        is_kw = ((len == POS_BITS'(csl_pkg::KW_RETURN_LEN)) && (p == csl_pkg::KW_RETURN)) ||
                ((len == POS_BITS'(csl_pkg::KW_IF_LEN))     && (p == csl_pkg::KW_IF))     ||
                ((len == POS_BITS'(csl_pkg::KW_ELSE_LEN))   && (p == csl_pkg::KW_ELSE))   ||
                ((len == POS_BITS'(csl_pkg::KW_WHILE_LEN))  && (p == csl_pkg::KW_WHILE))  ||
                ((len == POS_BITS'(csl_pkg::KW_FOR_LEN))    && (p == csl_pkg::KW_FOR));
    endfunction

    function automatic t_tok mk(input csl_pkg::t_token_kind k,
                                input logic [POS_BITS-1:0] s,
                                input logic [POS_BITS-1:0] l,
                                input logic [VALUE_BITS-1:0] v,
                                input logic [7:0] pc);
        t_tok t;
        t.kind   = k;
        t.start  = s;
        t.length = l;
        t.value  = v;
        t.punct  = pc;
        t.last   = 1'b0;
        mk = t;
    endfunction

    assign fire       = r_in_valid && i_room;
    assign o_in_ready = !r_in_valid || i_room;
    assign digit      = r_byte[3:0];
    assign acc_x10    = ({4'b0, r_accum} << 3) + ({4'b0, r_accum} << 1)
                        + (VALUE_BITS + 4)'(digit);

    always_comb begin
        n_mode   = r_mode;
        n_start  = r_start;
        n_len    = r_len;
        n_accum  = r_accum;
        n_prefix = r_prefix;
        n_punct  = r_punct;
        n_offset = r_offset;
        used     = 1'b0;
        va       = 1'b0;
        vm       = 1'b0;
        ve       = 1'b0;
        tok_a    = '0;
        tok_m    = '0;
        tok_e    = '0;

        // continue or close the pending token
        unique case (r_mode)
            MODE_ERROR: used = 1'b1;
            MODE_PUNCT: begin
                va = 1'b1;
                if (r_byte == csl_pkg::CH_EQ) begin
                    tok_a  = mk(csl_pkg::KIND_PUNCT, r_start, POS_BITS'(2), '0, r_punct);
                    n_mode = MODE_IDLE;
                    used   = 1'b1;
                end else if (r_punct == csl_pkg::CH_BANG) begin
                    tok_a  = mk(csl_pkg::KIND_BAD, r_start, POS_BITS'(1), '0, r_punct);
                    n_mode = MODE_ERROR;
                    used   = 1'b1;
                end else begin
                    tok_a  = mk(csl_pkg::KIND_PUNCT, r_start, POS_BITS'(1), '0, r_punct);
                    n_mode = MODE_IDLE;
                end
            end
            MODE_NUM: begin
                if (csl_pkg::is_digit(r_byte)) begin
                    if (acc_x10[VALUE_BITS+3:VALUE_BITS] != '0) begin
                        n_accum = '1;
                    end else begin
                        n_accum = acc_x10[VALUE_BITS-1:0];
                    end
                    n_len = sat_inc(r_len);
                    used  = 1'b1;
                end else begin
                    va     = 1'b1;
                    tok_a  = mk(csl_pkg::KIND_NUM, r_start, r_len, r_accum, 8'h00);
                    n_mode = MODE_IDLE;
                end
            end
            MODE_IDENT: begin
                if (csl_pkg::is_ident_head(r_byte) || csl_pkg::is_digit(r_byte)) begin
                    if (r_len < POS_BITS'(csl_pkg::PREFIX_BYTES)) begin
                        n_prefix = {r_prefix[39:0], r_byte};
                    end
                    n_len = sat_inc(r_len);
                    used  = 1'b1;
                end else begin
                    va     = 1'b1;
                    tok_a  = mk(is_kw(r_prefix, r_len) ? csl_pkg::KIND_KEYWORD
                                                       : csl_pkg::KIND_IDENT,
                                r_start, r_len, '0, 8'h00);
                    n_mode = MODE_IDLE;
                end
            end
            MODE_IDLE: ;
            default: ;
        endcase

        // start something new from this byte
        if (!used) begin
            if (csl_pkg::is_space(r_byte)) begin
                // skip
            end else if ((r_byte == csl_pkg::CH_EQ) || (r_byte == csl_pkg::CH_LT) ||
                         (r_byte == csl_pkg::CH_GT) || (r_byte == csl_pkg::CH_BANG)) begin
                n_mode  = MODE_PUNCT;
                n_punct = r_byte;
                n_start = r_offset;
            end else if (csl_pkg::is_single(r_byte)) begin
                vm    = 1'b1;
                tok_m = mk(csl_pkg::KIND_PUNCT, r_offset, POS_BITS'(1), '0, r_byte);
            end else if (csl_pkg::is_digit(r_byte)) begin
                n_mode  = MODE_NUM;
                n_accum = VALUE_BITS'(digit);
                n_len   = POS_BITS'(1);
                n_start = r_offset;
            end else if (csl_pkg::is_ident_head(r_byte)) begin
                n_mode   = MODE_IDENT;
                n_prefix = {40'b0, r_byte};
                n_len    = POS_BITS'(1);
                n_start  = r_offset;
            end else begin
                vm     = 1'b1;
                tok_m  = mk(csl_pkg::KIND_BAD, r_offset, POS_BITS'(1), '0, r_byte);
                n_mode = MODE_ERROR;
            end
        end

        n_offset = sat_inc(r_offset);

        // final byte: flush what is pending, append end, clear state
        if (r_last) begin
            unique case (n_mode)
                MODE_PUNCT: begin
                    vm    = 1'b1;
                    tok_m = mk((n_punct == csl_pkg::CH_BANG) ? csl_pkg::KIND_BAD
                                                             : csl_pkg::KIND_PUNCT,
                               n_start, POS_BITS'(1), '0, n_punct);
                end
                MODE_NUM: begin
                    vm    = 1'b1;
                    tok_m = mk(csl_pkg::KIND_NUM, n_start, n_len, n_accum, 8'h00);
                end
                MODE_IDENT: begin
                    vm    = 1'b1;
                    tok_m = mk(is_kw(n_prefix, n_len) ? csl_pkg::KIND_KEYWORD
                                                      : csl_pkg::KIND_IDENT,
                               n_start, n_len, '0, 8'h00);
                end
                MODE_IDLE, MODE_ERROR: ;
                default: ;
            endcase
            ve       = 1'b1;
            tok_e    = mk(csl_pkg::KIND_END, n_offset, '0, '0, 8'h00);
            n_mode   = MODE_IDLE;
            n_start  = '0;
            n_len    = '0;
            n_accum  = '0;
            n_prefix = '0;
            n_punct  = '0;
            n_offset = '0;
        end
    end

    // pack valid tokens in order and flag the last one
    always_comb begin
        for (int i = 0; i < csl_pkg::MAX_RESULTS; i++) begin
            slot[i] = '0;
        end
        cnt = 2'd0;
        if (va) begin
            slot[cnt] = tok_a;
            cnt       = cnt + 2'd1;
        end
        if (vm) begin
            slot[cnt] = tok_m;
            cnt       = cnt + 2'd1;
        end
        if (ve) begin
            slot[cnt] = tok_e;
            cnt       = cnt + 2'd1;
        end
        if (cnt != 2'd0) begin
            slot[cnt - 2'd1].last = 1'b1;
        end
        o_push_cnt = fire ? cnt : 2'd0;
        for (int i = 0; i < csl_pkg::MAX_RESULTS; i++) begin
            o_push_data[i] = slot[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_byte <= i_text_byte;
            r_last <= i_end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_IDLE;
            r_start    <= '0;
            r_len      <= '0;
            r_accum    <= '0;
            r_prefix   <= '0;
            r_punct    <= '0;
            r_offset   <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_mode   <= n_mode;
                r_start  <= n_start;
                r_len    <= n_len;
                r_accum  <= n_accum;
                r_prefix <= n_prefix;
                r_punct  <= n_punct;
                r_offset <= n_offset;
            end
        end
    end

endmodule

// ===== src/c_subset_lexer.sv =====
// A byte accepted into the input register is scanned there, and the tokens it yields are
// written into the result queue once that has room; the output reads the queue's registers.
// Throughput: one byte per cycle while each byte yields at most one token and the output
// is taken; the four-entry result queue holds input back when fewer than three slots are
// free. A byte giving two or three tokens leaves them queued to be handed out in turn.
// Reset (i_rst_n low, synchronous) empties the queue and returns the scanner to
// idle at offset 0.
module c_subset_lexer #(
    parameter int POS_BITS   = csl_pkg::POS_BITS_DEF,
    parameter int VALUE_BITS = csl_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_text_byte,
    input  logic                  i_end_of_text,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_token_kind,
    output logic [POS_BITS-1:0]   o_token_start,
    output logic [POS_BITS-1:0]   o_token_length,
    output logic [VALUE_BITS-1:0] o_number_value,
    output logic [7:0]            o_punct_char,
    output logic                  o_run_last
);
    localparam int TOK_W = 3 + 2 * POS_BITS + VALUE_BITS + 8 + 1;

    logic [1:0]       push_cnt;
    logic [TOK_W-1:0] push_data [csl_pkg::MAX_RESULTS];
    logic             room;
    logic [TOK_W-1:0] out_data;

    csl_scan_core #(
        .POS_BITS   (POS_BITS),
        .VALUE_BITS (VALUE_BITS),
        .TOK_W      (TOK_W)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_room        (room),
        .o_push_cnt    (push_cnt),
        .o_push_data   (push_data)
    );

    csl_token_fifo #(
        .DATA_W (TOK_W)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_cnt  (push_cnt),
        .i_push_data (push_data),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (out_data)
    );

    // token word layout: kind, start, length, value, punct, last (bit 0)
    assign o_run_last     = out_data[0];
    assign o_punct_char   = out_data[8:1];
    assign o_number_value = out_data[VALUE_BITS+8:9];
    assign o_token_length = out_data[POS_BITS+VALUE_BITS+8:VALUE_BITS+9];
    assign o_token_start  = out_data[2*POS_BITS+VALUE_BITS+8:POS_BITS+VALUE_BITS+9];
    assign o_token_kind   = out_data[TOK_W-1:TOK_W-3];

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for c_subset_lexer: byte stream in, token words checked in order.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              HALF_PERIOD  = 1;
    localparam int              RESET_CYCLES = 7;
    localparam int unsigned     CYCLE_LIMIT  = 100_000;
    localparam int              DRAIN_CYCLES = 16;
    localparam int              HOLD_CYCLES  = 120;
    localparam int unsigned     RANDOM_BYTES = 16;
    localparam int              LONG_DIGITS  = 12;
    localparam int              REPORT_LIMIT = 10;
    localparam int unsigned     POS_MAX      = (1 << csl_pkg::POS_BITS_DEF) - 1;
    localparam longint unsigned VALUE_MAX    = (64'd1 << csl_pkg::VALUE_BITS_DEF) - 1;
    localparam logic [7:0]      CH_ZERO      = "0";
    localparam logic [7:0]      CH_PLUS      = "+";
    localparam logic [7:0]      CH_SPACE     = 8'h20;
    localparam string           SINGLES      = "+-*/()<>;={},";
    localparam string           PAIR_HEADS   = "=!<>";

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_PUNCT,
        SCAN_NUM,
        SCAN_NAME,
        SCAN_SKIP
    } t_scan_mode;

    typedef struct {
        csl_pkg::t_token_kind               kind;
        logic [csl_pkg::POS_BITS_DEF-1:0]   start;
        logic [csl_pkg::POS_BITS_DEF-1:0]   length;
        logic [csl_pkg::VALUE_BITS_DEF-1:0] value;
        logic [7:0]                         pchar;
        logic                               last;
    } t_token;

    string KEYWORDS [5] = '{"return", "if", "else", "while", "for"};

    logic                               i_clk          = 1'b0;
    logic                               i_rst_n        = 1'b0;
    logic                               i_in_valid     = 1'b0;
    logic                               o_in_ready;
    logic [7:0]                         i_text_byte    = 8'h00;
    logic                               i_end_of_text  = 1'b0;
    logic                               o_out_valid;
    logic                               i_out_ready    = 1'b0;
    logic [2:0]                         o_token_kind;
    logic [csl_pkg::POS_BITS_DEF-1:0]   o_token_start;
    logic [csl_pkg::POS_BITS_DEF-1:0]   o_token_length;
    logic [csl_pkg::VALUE_BITS_DEF-1:0] o_number_value;
    logic [7:0]                         o_punct_char;
    logic                               o_run_last;

    // Token predictor state
    t_scan_mode      scan        = SCAN_IDLE;
    int unsigned     tok_start   = 0;
    int unsigned     tok_len     = 0;
    int unsigned     text_pos    = 0;
    longint unsigned num_acc     = 0;
    logic [47:0]     name_prefix = '0;
    logic [7:0]      held_punct  = 8'h00;

    t_token      expected_tokens[$];
    t_token      want;
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    bit          idle_on     = 1'b1;
    int unsigned stall_kicks = 0;
    int unsigned stall_seen  = 0;
    int unsigned hold_left   = 0;
    int unsigned gap_left    = 0;

    c_subset_lexer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_text_byte    (i_text_byte),
        .i_end_of_text  (i_end_of_text),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_number_value (o_number_value),
        .o_punct_char   (o_punct_char),
        .o_run_last     (o_run_last)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic bit ws_char(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic bit digit_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit name_head(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit single_punct(input logic [7:0] c);
        for (int i = 0; i < SINGLES.len(); i++)
            if (SINGLES[i] == c) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit name_is_keyword(input logic [47:0] prefix, input int unsigned len);
        return (len == csl_pkg::KW_RETURN_LEN && prefix == csl_pkg::KW_RETURN) ||
               (len == csl_pkg::KW_IF_LEN     && prefix == csl_pkg::KW_IF)     ||
               (len == csl_pkg::KW_ELSE_LEN   && prefix == csl_pkg::KW_ELSE)   ||
               (len == csl_pkg::KW_WHILE_LEN  && prefix == csl_pkg::KW_WHILE)  ||
               (len == csl_pkg::KW_FOR_LEN    && prefix == csl_pkg::KW_FOR);
    endfunction

    function automatic int unsigned pos_inc(input int unsigned v);
        return (v >= POS_MAX) ? POS_MAX : v + 1;
    endfunction

    task automatic push_token(input csl_pkg::t_token_kind k, input int unsigned st,
                              input int unsigned len, input longint unsigned v,
                              input logic [7:0] pc);
        t_token t;
        t.kind   = k;
        t.start  = st[csl_pkg::POS_BITS_DEF-1:0];
        t.length = len[csl_pkg::POS_BITS_DEF-1:0];
        t.value  = v[csl_pkg::VALUE_BITS_DEF-1:0];
        t.pchar  = pc;
        t.last   = 1'b0;
        expected_tokens.push_back(t);
    endtask

    task automatic clear_scanner();
        scan        = SCAN_IDLE;
        tok_start   = 0;
        tok_len     = 0;
        text_pos    = 0;
        num_acc     = 0;
        name_prefix = '0;
        held_punct  = 8'h00;
    endtask

    // Emit whatever token is open and go idle; a held '!' instead turns into an error and the scanner skips.
    task automatic close_token();
        case (scan)
            SCAN_PUNCT: begin
                if (held_punct == csl_pkg::CH_BANG) begin
                    push_token(csl_pkg::KIND_BAD, tok_start, 1, 0, held_punct);
                    scan = SCAN_SKIP;
                    return;
                end
                push_token(csl_pkg::KIND_PUNCT, tok_start, 1, 0, held_punct);
            end
            SCAN_NUM: push_token(csl_pkg::KIND_NUM, tok_start, tok_len, num_acc, 8'h00);
            SCAN_NAME: begin
                if (name_is_keyword(name_prefix, tok_len))
                    push_token(csl_pkg::KIND_KEYWORD, tok_start, tok_len, 0, 8'h00);
                else
                    push_token(csl_pkg::KIND_IDENT, tok_start, tok_len, 0, 8'h00);
            end
            default: return;
        endcase
        scan = SCAN_IDLE;
    endtask

    task automatic lex_byte(input logic [7:0] c, input logic eot);
        int unsigned     pos;
        int unsigned     before_count;
        bit              used;
        longint unsigned d;
        t_token          t;
        pos          = text_pos;
        before_count = expected_tokens.size();
        used         = 1'b0;
        case (scan)
            SCAN_SKIP: used = 1'b1;
            SCAN_PUNCT: begin
                if (c == csl_pkg::CH_EQ) begin
                    push_token(csl_pkg::KIND_PUNCT, tok_start, 2, 0, held_punct);
                    scan = SCAN_IDLE;
                    used = 1'b1;
                end else begin
                    close_token();
                    if (scan == SCAN_SKIP) used = 1'b1;
                end
            end
            SCAN_NUM: begin
                if (digit_char(c)) begin
                    d = longint'(c - CH_ZERO);
                    if (num_acc > (VALUE_MAX - d) / 10)
                        num_acc = VALUE_MAX;
                    else
                        num_acc = num_acc * 10 + d;
                    tok_len = pos_inc(tok_len);
                    used    = 1'b1;
                end else begin
                    close_token();
                end
            end
            SCAN_NAME: begin
                if (name_head(c) || digit_char(c)) begin
                    if (tok_len < csl_pkg::PREFIX_BYTES) name_prefix = {name_prefix[39:0], c};
                    tok_len = pos_inc(tok_len);
                    used    = 1'b1;
                end else begin
                    close_token();
                end
            end
            default: ;
        endcase

        if (!used) begin
            if (ws_char(c)) begin
                // skip
            end else if (c == csl_pkg::CH_EQ || c == csl_pkg::CH_LT ||
                         c == csl_pkg::CH_GT || c == csl_pkg::CH_BANG) begin
                scan       = SCAN_PUNCT;
                held_punct = c;
                tok_start  = pos;
            end else if (single_punct(c)) begin
                push_token(csl_pkg::KIND_PUNCT, pos, 1, 0, c);
            end else if (digit_char(c)) begin
                scan      = SCAN_NUM;
                num_acc   = longint'(c - CH_ZERO);
                tok_len   = 1;
                tok_start = pos;
            end else if (name_head(c)) begin
                scan        = SCAN_NAME;
                name_prefix = {40'd0, c};
                tok_len     = 1;
                tok_start   = pos;
            end else begin
                push_token(csl_pkg::KIND_BAD, pos, 1, 0, c);
                scan = SCAN_SKIP;
            end
        end

        text_pos = pos_inc(pos);
        if (eot) begin
            close_token();
            push_token(csl_pkg::KIND_END, text_pos, 0, 0, 8'h00);
            clear_scanner();
        end

        if (expected_tokens.size() > before_count) begin
            t      = expected_tokens.pop_back();
            t.last = 1'b1;
            expected_tokens.push_back(t);
        end
    endtask

    // ---------------------------------------------------------------- output side

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected token at cycle %0d: kind %0d start %0d len %0d",
                             cycle_count, o_token_kind, o_token_start, o_token_length);
            end else begin
                want = expected_tokens.pop_front();
                if (o_token_kind !== want.kind || o_token_start !== want.start ||
                    o_token_length !== want.length || o_number_value !== want.value ||
                    o_punct_char !== want.pchar || o_run_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("token mismatch at cycle %0d:", cycle_count,
                                 " expected kind %0d start %0d len %0d value %0d",
                                 want.kind, want.start, want.length, want.value,
                                 " char %02h last %0b;", want.pchar, want.last,
                                 " got kind %0d start %0d len %0d value %0d",
                                 o_token_kind, o_token_start, o_token_length,
                                 o_number_value,
                                 " char %02h last %0b", o_punct_char, o_run_last);
                end
            end
        end

        // Pick up a long hold-off request, otherwise stall in short random bursts while idle_on is set
        if (stall_seen != stall_kicks) begin
            stall_seen = stall_kicks;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            gap_left = $urandom_range(1, 5) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- input side

    task automatic send_byte(input logic [7:0] c, input logic eot);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_text_byte   <= c;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (!o_in_ready);
        lex_byte(c, eot);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] space_char();
        int unsigned v;
        v = $urandom_range(0, 5);
        return (v == 5) ? CH_SPACE : 8'(8'h09 + v);
    endfunction

    function automatic logic [7:0] name_char(input bit head);
        int unsigned v;
        v = $urandom_range(0, head ? 52 : 62);
        if (v < 26) return 8'("a" + v);
        if (v < 52) return 8'("A" + v - 26);
        if (v == 52) return "_";
        return 8'("0" + v - 53);
    endfunction

    // Build a text of random well-formed tokens with rare noise, then stream it.
    task automatic send_random_text(output int unsigned sent);
        logic [7:0]  chars[$];
        string       word;
        int unsigned count;
        int unsigned len;
        int unsigned pick;
        count = $urandom_range(3, 12);
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 39);
            if (pick < 8) begin
                word = KEYWORDS[$urandom_range(0, 4)];
                for (int i = 0; i < word.len(); i++) chars.push_back(word[i]);
            end else if (pick < 15) begin
                len = $urandom_range(1, 9);
                chars.push_back(name_char(1'b1));
                repeat (len - 1) chars.push_back(name_char(1'b0));
            end else if (pick < 22) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
                repeat (len) chars.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            end else if (pick < 28) begin
                chars.push_back(SINGLES[$urandom_range(0, SINGLES.len() - 1)]);
            end else if (pick < 32) begin
                chars.push_back(PAIR_HEADS[$urandom_range(0, 3)]);
                chars.push_back(csl_pkg::CH_EQ);
            end else if (pick < 38) begin
                repeat ($urandom_range(1, 3)) chars.push_back(space_char());
            end else if (pick == 38) begin
                chars.push_back(csl_pkg::CH_BANG);
                chars.push_back(name_char(1'b0));
            end else begin
                chars.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 1) == 1) chars.push_back(space_char());
        end
        for (int i = 0; i < chars.size(); i++)
            send_byte(chars[i], i == chars.size() - 1);
        sent = chars.size();
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_punctuators();
        // every single punctuator, every pair, and pairs that fall apart
        send_text("(<=>=!====<>,){};+-*/");
    endtask

    task automatic test_numbers_and_names();
        // value just past the top saturates; long name is never a keyword
        send_text("2147483648 if _Az09xyz");
    endtask

    task automatic test_bad_bytes();
        send_text("!a+");
        send_byte(8'h00, 1'b1);
        send_byte("x", 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte("9", 1'b1);
        send_text("!");
    endtask

    task automatic test_output_stall();
        stall_kicks <= stall_kicks + 1;
        send_text("a+b;c=d*e;x<=y;n=12+34;{f(g,h)}");
    endtask

    task automatic test_long_text();
        // a twelve-digit number drives the value into saturation
        send_byte("1", 1'b0);
        repeat (LONG_DIGITS - 1) send_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
        send_byte(CH_PLUS, 1'b1);
    endtask

    task automatic test_random_texts();
        int unsigned total;
        int unsigned sent;
        total = 0;
        while (total < RANDOM_BYTES) begin
            send_random_text(sent);
            total += sent;
        end
    endtask

    task automatic test_steady_stream();
        int unsigned sent;
        idle_on = 1'b0;
        send_random_text(sent);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_punctuators();
        test_numbers_and_names();
        test_bad_bytes();
        test_output_stall();
        test_long_text();
        test_random_texts();
        test_steady_stream();
        i_in_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/csl_pkg.sv
src/csl_token_fifo.sv
src/csl_scan_core.sv
src/c_subset_lexer.sv
tb/tb.sv
